>>> sv/ffha_pkg.sv
package ffha_pkg;

    // Command codes carried in the input tuser field.
    localparam logic [1:0] CMD_ALLOC  = 2'd0;
    localparam logic [1:0] CMD_FREE   = 2'd1;
    localparam logic [1:0] CMD_REINIT = 2'd2;

    // Result status codes.
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOFIT   = 2'd2;
    localparam logic [1:0] ST_UNKNOWN = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    // Register values after reset, and the heap size limit.
    localparam logic [31:0] HEAP_BASE_RST  = 32'h0040_0000;
    localparam logic [24:0] HEAP_BYTES_RST = 25'd4194304;
    localparam logic [24:0] HEAP_LIMIT     = 25'd16777216;

    // Datapath operation codes.
    localparam logic [4:0] OP_NONE       = 5'd0;
    localparam logic [4:0] OP_INIT       = 5'd1;
    localparam logic [4:0] OP_LOAD       = 5'd2;
    localparam logic [4:0] OP_REBUILD    = 5'd3;
    localparam logic [4:0] OP_SCAN_START = 5'd4;
    localparam logic [4:0] OP_RD_IDX     = 5'd5;
    localparam logic [4:0] OP_SCAN_NEXT  = 5'd6;
    localparam logic [4:0] OP_HIT        = 5'd7;
    localparam logic [4:0] OP_UP_RD      = 5'd8;
    localparam logic [4:0] OP_UP_WR      = 5'd9;
    localparam logic [4:0] OP_SPLIT_WR   = 5'd10;
    localparam logic [4:0] OP_ALLOC_WR   = 5'd11;
    localparam logic [4:0] OP_NEXT_RD    = 5'd12;
    localparam logic [4:0] OP_NEXT_LATCH = 5'd13;
    localparam logic [4:0] OP_NO_NEXT    = 5'd14;
    localparam logic [4:0] OP_MERGE_WR   = 5'd15;
    localparam logic [4:0] OP_DN_RD      = 5'd16;
    localparam logic [4:0] OP_DN_WR      = 5'd17;
    localparam logic [4:0] OP_DN_END     = 5'd18;
    localparam logic [4:0] OP_SET_STATUS = 5'd19;
    localparam logic [4:0] OP_POST       = 5'd20;

    // One row of the block table.
    typedef struct packed {
        logic [23:0] start;
        logic [23:0] size;
        logic        free;
    } t_entry;

    // Command from the controller to the datapath.
    typedef struct packed {
        logic [4:0] op;
        logic [1:0] status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [1:0] cmd;
        logic       req_zero;
        logic       addr_null;
        logic       scan_end;
        logic       match;
        logic       split;
        logic       up_done;
        logic       has_next;
        logic       dn_done;
        logic       out_free;
    } t_dp_sts;

endpackage

>>> sv/ffha_ctrl.sv
module ffha_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ffha_pkg::t_dp_sts  i_sts,
    output ffha_pkg::t_dp_cmd  o_cmd
);

    localparam logic [3:0] S_INIT  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_DISP  = 4'd2;
    localparam logic [3:0] S_RD    = 4'd3;
    localparam logic [3:0] S_CHK   = 4'd4;
    localparam logic [3:0] S_UP_RD = 4'd5;
    localparam logic [3:0] S_UP_WR = 4'd6;
    localparam logic [3:0] S_AWR   = 4'd7;
    localparam logic [3:0] S_NRD   = 4'd8;
    localparam logic [3:0] S_NCHK  = 4'd9;
    localparam logic [3:0] S_MRG   = 4'd10;
    localparam logic [3:0] S_DN_RD = 4'd11;
    localparam logic [3:0] S_DN_WR = 4'd12;
    localparam logic [3:0] S_DONE  = 4'd13;

    logic [3:0] r_state;
    logic [3:0] n_state;

    assign o_in_ready = (r_state == S_IDLE);

    // Next state and datapath command.
    always_comb begin
        n_state       = r_state;
        o_cmd.op      = ffha_pkg::OP_NONE;
        o_cmd.status  = ffha_pkg::ST_OK;
        unique case (r_state)
            S_INIT: begin
                o_cmd.op = ffha_pkg::OP_INIT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = ffha_pkg::OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                case (i_sts.cmd)
                    ffha_pkg::CMD_ALLOC: begin
                        if (i_sts.req_zero) begin
                            o_cmd.op     = ffha_pkg::OP_SET_STATUS;
                            o_cmd.status = ffha_pkg::ST_ZERO;
                        end else begin
                            o_cmd.op = ffha_pkg::OP_SCAN_START;
                            n_state  = S_RD;
                        end
                    end
                    ffha_pkg::CMD_FREE: begin
                        if (!i_sts.addr_null) begin
                            o_cmd.op = ffha_pkg::OP_SCAN_START;
                            n_state  = S_RD;
                        end
                    end
                    ffha_pkg::CMD_REINIT: begin
                        o_cmd.op = ffha_pkg::OP_REBUILD;
                    end
                    default: begin
                        o_cmd.op = ffha_pkg::OP_NONE;
                    end
                endcase
            end
            S_RD: begin
                if (i_sts.scan_end) begin
                    o_cmd.op     = ffha_pkg::OP_SET_STATUS;
                    o_cmd.status = (i_sts.cmd == ffha_pkg::CMD_ALLOC) ?
                                   ffha_pkg::ST_NOFIT : ffha_pkg::ST_UNKNOWN;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.op = ffha_pkg::OP_RD_IDX;
                    n_state  = S_CHK;
                end
            end
            S_CHK: begin
                if (i_sts.match) begin
                    o_cmd.op = ffha_pkg::OP_HIT;
                    n_state  = (i_sts.cmd == ffha_pkg::CMD_ALLOC) ? S_UP_RD : S_NRD;
                end else begin
                    o_cmd.op = ffha_pkg::OP_SCAN_NEXT;
                    n_state  = S_RD;
                end
            end
            S_UP_RD: begin
                if (!i_sts.split) begin
                    n_state = S_AWR;
                end else if (i_sts.up_done) begin
                    o_cmd.op = ffha_pkg::OP_SPLIT_WR;
                    n_state  = S_AWR;
                end else begin
                    o_cmd.op = ffha_pkg::OP_UP_RD;
                    n_state  = S_UP_WR;
                end
            end
            S_UP_WR: begin
                o_cmd.op = ffha_pkg::OP_UP_WR;
                n_state  = S_UP_RD;
            end
            S_AWR: begin
                o_cmd.op = ffha_pkg::OP_ALLOC_WR;
                n_state  = S_DONE;
            end
            S_NRD: begin
                if (i_sts.has_next) begin
                    o_cmd.op = ffha_pkg::OP_NEXT_RD;
                    n_state  = S_NCHK;
                end else begin
                    o_cmd.op = ffha_pkg::OP_NO_NEXT;
                    n_state  = S_MRG;
                end
            end
            S_NCHK: begin
                o_cmd.op = ffha_pkg::OP_NEXT_LATCH;
                n_state  = S_MRG;
            end
            S_MRG: begin
                o_cmd.op = ffha_pkg::OP_MERGE_WR;
                n_state  = S_DN_RD;
            end
            S_DN_RD: begin
                if (i_sts.dn_done) begin
                    o_cmd.op = ffha_pkg::OP_DN_END;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = ffha_pkg::OP_DN_RD;
                    n_state  = S_DN_WR;
                end
            end
            S_DN_WR: begin
                o_cmd.op = ffha_pkg::OP_DN_WR;
                n_state  = S_DN_RD;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.op = ffha_pkg::OP_POST;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef ASSERT_OFF
    // A result is only posted from the final state.
    a_post_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == ffha_pkg::OP_POST) |-> (r_state == S_DONE))
        else $error("result posted outside the done state");

    // Every accepted item is dispatched in the next cycle.
    a_load_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == ffha_pkg::OP_LOAD) |=> (r_state == S_DISP))
        else $error("accepted item was not dispatched");
`endif

endmodule

>>> sv/ffha_dpath.sv
module ffha_dpath #(
    parameter int MAX_BLOCKS      = 64,
    parameter int HEADER_BYTES    = 12,
    parameter int MIN_SPLIT_BYTES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [31:0]        i_cfg_wdata,
    input  logic [1:0]         i_command,
    input  logic [23:0]        i_request_size,
    input  logic [31:0]        i_free_address,
    input  ffha_pkg::t_dp_cmd  i_cmd,
    output ffha_pkg::t_dp_sts  o_sts,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_status,
    output logic [31:0]        o_payload_address,
    output logic [24:0]        o_bytes_allocated
);

    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAX_C     = CW'(MAX_BLOCKS);
    localparam logic [25:0]   SPLIT26   = 26'(HEADER_BYTES + MIN_SPLIT_BYTES);
    localparam logic [24:0]   HDR25     = 25'(HEADER_BYTES);
    localparam logic [23:0]   HDR24     = 24'(HEADER_BYTES);
    localparam logic [31:0]   HDR32     = 32'(HEADER_BYTES);
    localparam logic [23:0]   RST_SIZE  = 24'(ffha_pkg::HEAP_BYTES_RST - HDR25);

    // Block table memory.
    ffha_pkg::t_entry r_mem [MAX_BLOCKS];
    ffha_pkg::t_entry r_rd;

    // Configuration registers.
    logic [31:0] r_heap_base;
    logic [24:0] r_heap_bytes;

    // Item and table state.
    logic [1:0]    r_cmd;
    logic          r_req_zero;
    logic [24:0]   r_aligned;
    logic [31:0]   r_faddr;
    logic [CW-1:0] r_count;
    logic [24:0]   r_total;
    logic [CW-1:0] r_idx;
    logic [CW-1:0] r_k;
    logic [IW-1:0] r_hit;
    logic          r_split;
    logic [1:0]    r_drop;
    ffha_pkg::t_entry r_prev;
    ffha_pkg::t_entry r_cur;
    logic          r_nxt_free;
    logic [23:0]   r_nxt_size;
    logic [1:0]    r_status;
    logic [31:0]   r_addr;

    // Output register.
    logic          r_ovalid;
    logic [1:0]    r_o_status;
    logic [31:0]   r_o_addr;
    logic [24:0]   r_o_total;

    logic             w_we;
    logic [IW-1:0]    w_wa;
    ffha_pkg::t_entry w_wd;
    logic             w_re;
    logic [IW-1:0]    w_ra;
    logic [CW-1:0]    w_hit_p1;
    logic [CW:0]      w_k_plus_d;
    logic [IW-1:0]    w_lo;
    logic [24:0]      w_bytes_c;
    logic [23:0]      w_rebuild_size;
    logic [23:0]      w_merge_size;
    logic [23:0]      w_alloc_size;
    logic [25:0]      w_split_need;
    logic             w_addr_eq;

    assign w_hit_p1   = CW'(r_hit) + CW'(1);
    assign w_k_plus_d = {1'b0, r_k} + (CW+1)'(r_drop);
    assign w_lo       = r_prev.free ? (r_hit - IW'(1)) : r_hit;

    // Heap size clamp for a rebuild.
    assign w_bytes_c      = (r_heap_bytes > ffha_pkg::HEAP_LIMIT) ? ffha_pkg::HEAP_LIMIT
                                                                   : r_heap_bytes;
    assign w_rebuild_size = (w_bytes_c >= HDR25) ? 24'(w_bytes_c - HDR25) : 24'd0;

    // Merged block spans the freed block and any free neighbors.
    assign w_merge_size = r_cur.size
                        + (r_prev.free ? (r_prev.size + HDR24) : 24'd0)
                        + (r_nxt_free  ? (r_nxt_size  + HDR24) : 24'd0);

    assign w_alloc_size = r_split ? r_aligned[23:0] : r_cur.size;
    assign w_split_need = {1'b0, r_aligned} + SPLIT26;
    assign w_addr_eq    = ((r_heap_base + {8'd0, r_rd.start} + HDR32) == r_faddr);

    // Status toward the controller.
    always_comb begin
        o_sts.cmd       = r_cmd;
        o_sts.req_zero  = r_req_zero;
        o_sts.addr_null = (r_faddr == 32'd0);
        o_sts.scan_end  = (r_idx >= r_count);
        o_sts.match     = (r_cmd == ffha_pkg::CMD_ALLOC)
                        ? (r_rd.free && ({1'b0, r_rd.size} >= r_aligned))
                        : (!r_rd.free && w_addr_eq);
        o_sts.split     = r_split;
        o_sts.up_done   = (r_k == w_hit_p1);
        o_sts.has_next  = (w_hit_p1 < r_count);
        o_sts.dn_done   = (r_drop == 2'd0) || (w_k_plus_d >= {1'b0, r_count});
        o_sts.out_free  = !r_ovalid || i_out_ready;
    end

    // Memory port selection.
    always_comb begin
        w_we = 1'b0;
        w_wa = '0;
        w_wd = r_rd;
        w_re = 1'b0;
        w_ra = '0;
        unique case (i_cmd.op)
            ffha_pkg::OP_INIT: begin
                w_we = 1'b1;
                w_wd = '{start: 24'd0, size: RST_SIZE, free: 1'b1};
            end
            ffha_pkg::OP_REBUILD: begin
                w_we = 1'b1;
                w_wd = '{start: 24'd0, size: w_rebuild_size, free: 1'b1};
            end
            ffha_pkg::OP_RD_IDX: begin
                w_re = 1'b1;
                w_ra = r_idx[IW-1:0];
            end
            ffha_pkg::OP_UP_RD: begin
                w_re = 1'b1;
                w_ra = IW'(r_k - CW'(1));
            end
            ffha_pkg::OP_UP_WR: begin
                w_we = 1'b1;
                w_wa = r_k[IW-1:0];
            end
            ffha_pkg::OP_SPLIT_WR: begin
                w_we = 1'b1;
                w_wa = w_hit_p1[IW-1:0];
                w_wd = '{start: 24'({1'b0, r_cur.start} + HDR25 + r_aligned),
                         size:  24'({1'b0, r_cur.size} - r_aligned - HDR25),
                         free:  1'b1};
            end
            ffha_pkg::OP_ALLOC_WR: begin
                w_we = 1'b1;
                w_wa = r_hit;
                w_wd = '{start: r_cur.start, size: w_alloc_size, free: 1'b0};
            end
            ffha_pkg::OP_NEXT_RD: begin
                w_re = 1'b1;
                w_ra = w_hit_p1[IW-1:0];
            end
            ffha_pkg::OP_MERGE_WR: begin
                w_we = 1'b1;
                w_wa = w_lo;
                w_wd = '{start: r_prev.free ? r_prev.start : r_cur.start,
                         size:  w_merge_size, free: 1'b1};
            end
            ffha_pkg::OP_DN_RD: begin
                w_re = 1'b1;
                w_ra = w_k_plus_d[IW-1:0];
            end
            ffha_pkg::OP_DN_WR: begin
                w_we = 1'b1;
                w_wa = r_k[IW-1:0];
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Table memory with registered read.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        if (w_re) begin
            r_rd <= r_mem[w_ra];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= ffha_pkg::HEAP_BASE_RST;
            r_heap_bytes <= ffha_pkg::HEAP_BYTES_RST;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == ffha_pkg::CFG_HEAP_BASE) begin
                r_heap_base <= i_cfg_wdata;
            end else begin
                r_heap_bytes <= i_cfg_wdata[24:0];
            end
        end
    end

    // Table control state: block count and allocated total.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
            r_total <= 25'd0;
        end else begin
            case (i_cmd.op)
                ffha_pkg::OP_REBUILD: begin
                    r_count <= CW'(1);
                    r_total <= 25'd0;
                end
                ffha_pkg::OP_ALLOC_WR: begin
                    r_total <= r_total + {1'b0, w_alloc_size};
                    if (r_split) begin
                        r_count <= r_count + CW'(1);
                    end
                end
                ffha_pkg::OP_MERGE_WR: begin
                    r_total <= (r_total >= {1'b0, r_cur.size}) ?
                               r_total - {1'b0, r_cur.size} : 25'd0;
                end
                ffha_pkg::OP_DN_END: begin
                    r_count <= r_count - CW'(r_drop);
                end
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    // Working registers of one item.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            ffha_pkg::OP_LOAD: begin
                r_cmd      <= i_command;
                r_req_zero <= (i_request_size == 24'd0);
                r_aligned  <= ({1'b0, i_request_size} + 25'd3) & ~25'd3;
                r_faddr    <= i_free_address;
                r_status   <= ffha_pkg::ST_OK;
                r_addr     <= 32'd0;
            end
            ffha_pkg::OP_SET_STATUS: begin
                r_status <= i_cmd.status;
            end
            ffha_pkg::OP_SCAN_START: begin
                r_idx       <= '0;
                r_prev.free <= 1'b0;
            end
            ffha_pkg::OP_SCAN_NEXT: begin
                r_prev <= r_rd;
                r_idx  <= r_idx + CW'(1);
            end
            ffha_pkg::OP_HIT: begin
                r_cur   <= r_rd;
                r_hit   <= r_idx[IW-1:0];
                r_k     <= r_count;
                r_split <= (r_count < MAX_C) && ({2'b0, r_rd.size} >= w_split_need);
            end
            ffha_pkg::OP_UP_WR: begin
                r_k <= r_k - CW'(1);
            end
            ffha_pkg::OP_ALLOC_WR: begin
                r_addr <= r_heap_base + {8'd0, r_cur.start} + HDR32;
            end
            ffha_pkg::OP_NEXT_LATCH: begin
                r_nxt_free <= r_rd.free;
                r_nxt_size <= r_rd.size;
            end
            ffha_pkg::OP_NO_NEXT: begin
                r_nxt_free <= 1'b0;
            end
            ffha_pkg::OP_MERGE_WR: begin
                r_k    <= CW'(w_lo) + CW'(1);
                r_drop <= {1'b0, r_prev.free} + {1'b0, r_nxt_free};
            end
            ffha_pkg::OP_DN_WR: begin
                r_k <= r_k + CW'(1);
            end
            default: begin
                r_k <= r_k;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == ffha_pkg::OP_POST) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == ffha_pkg::OP_POST) begin
            r_o_status <= r_status;
            r_o_addr   <= (r_status == ffha_pkg::ST_OK) ? r_addr : 32'd0;
            r_o_total  <= r_total;
        end
    end

    assign o_out_valid       = r_ovalid;
    assign o_status          = r_o_status;
    assign o_payload_address = r_o_addr;
    assign o_bytes_allocated = r_o_total;

`ifndef ASSERT_OFF
    // The table always holds between one and the maximum number of blocks.
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= MAX_C))
        else $error("block count out of range");

    // Scan reads stay inside the live part of the table.
    a_scan_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ffha_pkg::OP_RD_IDX) |-> (r_idx < r_count))
        else $error("scan read beyond block count");

    // A result never overwrites one that has not been taken.
    a_post_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ffha_pkg::OP_POST) |-> (!r_ovalid || i_out_ready))
        else $error("result register overwritten");

    // A split only happens while the table has room.
    a_split_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ffha_pkg::OP_SPLIT_WR) |-> (r_count < MAX_C))
        else $error("split with full table");
`endif

endmodule

>>> sv/first_fit_heap_allocator.sv
// Channel   Direction  Contents
// s_axis    in         tuser: command[1:0]; tdata: request_size, free_address
// m_axis    out        tdata: status, payload_address, bytes_allocated
// i_cfg_*   in         index 0 heap_base, used at once; index 1 heap_bytes, used at reinitialise
//
// One item at a time. An allocate or free scans the table, reading and checking
// each block in turn, then a split shifts later blocks up and a merge shifts
// them down with a read and a write per block. The result is posted from the
// done state once the output register is free, so an output stall holds it.
// After reset the initial free block is loaded before input is taken.
// A finished result waits in the output register while the next item is taken.
module first_fit_heap_allocator #(
    parameter int MAX_BLOCKS      = 64,
    parameter int HEADER_BYTES    = 12,
    parameter int MIN_SPLIT_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // request_size[23:0], free_address[55:24]
    input  logic [55:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], payload_address[33:2], bytes_allocated[58:34], zeros above
    output logic [63:0] m_axis_tdata
);

    ffha_pkg::t_dp_cmd w_cmd;
    ffha_pkg::t_dp_sts w_sts;
    logic [1:0]  w_status;
    logic [31:0] w_addr;
    logic [24:0] w_total;

    ffha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    ffha_dpath #(
        .MAX_BLOCKS      (MAX_BLOCKS),
        .HEADER_BYTES    (HEADER_BYTES),
        .MIN_SPLIT_BYTES (MIN_SPLIT_BYTES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata),
        .i_command         (s_axis_tuser),
        .i_request_size    (s_axis_tdata[23:0]),
        .i_free_address    (s_axis_tdata[55:24]),
        .i_cmd             (w_cmd),
        .o_sts             (w_sts),
        .o_out_valid       (m_axis_tvalid),
        .i_out_ready       (m_axis_tready),
        .o_status          (w_status),
        .o_payload_address (w_addr),
        .o_bytes_allocated (w_total)
    );

    assign m_axis_tdata = {5'd0, w_total, w_addr, w_status};

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int TABLE_DEPTH = 64;
    localparam int HDR = 12;
    localparam int SPLIT_MIN = 16;

    // One predicted allocator response.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] paddr;
        logic [24:0] total;
    } t_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic        i_cfg_index;
    logic [31:0] i_cfg_wdata;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;

    first_fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_index(i_cfg_index), .i_cfg_wdata(i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    // Shadow copy of the heap table.
    logic [23:0] blk_start [TABLE_DEPTH];
    logic [23:0] blk_size [TABLE_DEPTH];
    logic        blk_free [TABLE_DEPTH];
    int          blk_count;
    logic [24:0] alloc_total;
    // Written registers; the heap size takes effect at the next reinitialise.
    logic [31:0] reg_base;
    logic [24:0] reg_bytes;

    t_resp       pending_resp[$];
    logic [31:0] live_addrs[$];
    int          mismatches;
    bit          idle_on;
    int          rx_hold;
    int          rx_gap;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Simulation FAILED");
        $finish;
    end

    // Rebuild the table as one free block spanning the heap.
    task automatic heap_rebuild();
        logic [24:0] span;
        span = (reg_bytes > ffha_pkg::HEAP_LIMIT) ? ffha_pkg::HEAP_LIMIT : reg_bytes;
        blk_start[0] = '0;
        blk_size[0] = (span >= HDR) ? 24'(span - HDR) : '0;
        blk_free[0] = 1'b1;
        blk_count = 1;
        alloc_total = '0;
        live_addrs.delete();
    endtask

    task automatic drop_block(input int idx);
        for (int k = idx; k + 1 < blk_count; k++) begin
            blk_start[k] = blk_start[k + 1];
            blk_size[k] = blk_size[k + 1];
            blk_free[k] = blk_free[k + 1];
        end
        blk_count--;
    endtask

    // First-fit allocate with optional split.
    task automatic heap_alloc(input logic [23:0] req, output logic [1:0] st,
                              output logic [31:0] pa);
        logic [31:0] aligned;
        int hit;
        hit = -1;
        pa = '0;
        if (req == 0) begin
            st = ffha_pkg::ST_ZERO;
            return;
        end
        aligned = (32'(req) + 32'd3) & ~32'd3;
        for (int i = 0; i < blk_count; i++) begin
            if (hit < 0 && blk_free[i] && 32'(blk_size[i]) >= aligned) hit = i;
        end
        if (hit < 0) begin
            st = ffha_pkg::ST_NOFIT;
            return;
        end
        if (blk_count < TABLE_DEPTH &&
            32'(blk_size[hit]) >= aligned + HDR + SPLIT_MIN) begin
            for (int k = blk_count; k > hit + 1; k--) begin
                blk_start[k] = blk_start[k - 1];
                blk_size[k] = blk_size[k - 1];
                blk_free[k] = blk_free[k - 1];
            end
            blk_start[hit + 1] = 24'(32'(blk_start[hit]) + HDR + aligned);
            blk_size[hit + 1] = 24'(32'(blk_size[hit]) - aligned - HDR);
            blk_free[hit + 1] = 1'b1;
            blk_size[hit] = 24'(aligned);
            blk_count++;
        end
        blk_free[hit] = 1'b0;
        alloc_total = alloc_total + 25'(blk_size[hit]);
        pa = reg_base + 32'(blk_start[hit]) + HDR;
        st = ffha_pkg::ST_OK;
        live_addrs.push_back(pa);
    endtask

    // Release a payload address and coalesce free neighbors.
    task automatic heap_release(input logic [31:0] addr, output logic [1:0] st);
        int i;
        int pos;
        st = ffha_pkg::ST_OK;
        if (addr == 0) return;
        st = ffha_pkg::ST_UNKNOWN;
        for (i = 0; i < blk_count; i++) begin
            if (!blk_free[i] && reg_base + 32'(blk_start[i]) + HDR == addr) break;
        end
        if (i >= blk_count) return;
        st = ffha_pkg::ST_OK;
        blk_free[i] = 1'b1;
        alloc_total = (alloc_total >= 25'(blk_size[i])) ? alloc_total - 25'(blk_size[i]) : '0;
        i = 0;
        while (i + 1 < blk_count) begin
            if (blk_free[i] && blk_free[i + 1]) begin
                blk_size[i] = 24'(32'(blk_size[i]) + HDR + 32'(blk_size[i + 1]));
                drop_block(i + 1);
            end else begin
                i++;
            end
        end
        pos = -1;
        for (int j = 0; j < live_addrs.size(); j++) begin
            if (pos < 0 && live_addrs[j] == addr) pos = j;
        end
        if (pos >= 0) live_addrs.delete(pos);
    endtask

    // Work out the response to one command.
    task automatic predict_heap(input logic [1:0] cmd, input logic [23:0] req,
                                input logic [31:0] addr);
        t_resp r;
        r.status = ffha_pkg::ST_OK;
        r.paddr = '0;
        case (cmd)
            ffha_pkg::CMD_ALLOC: heap_alloc(req, r.status, r.paddr);
            ffha_pkg::CMD_FREE: heap_release(addr, r.status);
            ffha_pkg::CMD_REINIT: heap_rebuild();
            default: ;
        endcase
        if (r.status != ffha_pkg::ST_OK) r.paddr = '0;
        r.total = alloc_total;
        pending_resp.push_back(r);
    endtask

    // Offer one item and wait until it is accepted.
    task automatic send_item(input logic [1:0] cmd, input logic [23:0] req,
                             input logic [31:0] addr);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {addr, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_heap(cmd, req, addr);
    endtask

    task automatic wait_drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_resp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both registers while idle, then reinitialise to apply them.
    task automatic set_heap(input logic [31:0] base, input logic [24:0] bytes_total);
        wait_drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= ffha_pkg::CFG_HEAP_BASE;
        i_cfg_wdata <= base;
        @(posedge i_clk);
        i_cfg_index <= ffha_pkg::CFG_HEAP_BYTES;
        i_cfg_wdata <= 32'(bytes_total);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        reg_base = base;
        reg_bytes = bytes_total;
        send_item(ffha_pkg::CMD_REINIT, 24'($urandom), $urandom);
    endtask

    task automatic free_random_live();
        if (live_addrs.size() == 0) send_item(ffha_pkg::CMD_FREE, '0, '0);
        else send_item(ffha_pkg::CMD_FREE, '0,
                       live_addrs[$urandom_range(0, live_addrs.size() - 1)]);
    endtask

    // Field extremes, every command and the simple special cases.
    task automatic test_commands();
        logic [31:0] first;
        send_item(ffha_pkg::CMD_ALLOC, 24'd1, '0);
        first = live_addrs[0];
        send_item(ffha_pkg::CMD_ALLOC, 24'd0, 32'hFFFF_FFFF);
        send_item(ffha_pkg::CMD_ALLOC, 24'hFF_FFFF, '0);
        send_item(ffha_pkg::CMD_ALLOC, 24'd4, '0);
        send_item(ffha_pkg::CMD_FREE, 24'hFF_FFFF, '0);
        send_item(ffha_pkg::CMD_FREE, '0, 32'hFFFF_FFFF);
        send_item(2'd3, 24'hFF_FFFF, 32'hFFFF_FFFF);
        send_item(ffha_pkg::CMD_FREE, '0, first);
        send_item(ffha_pkg::CMD_FREE, '0, first);
        send_item(ffha_pkg::CMD_ALLOC, 24'd7, '0);
        free_random_live();
        free_random_live();
        send_item(ffha_pkg::CMD_REINIT, '0, '0);
    endtask

    // Oversized, tiny and minimal heaps, and an address that wraps.
    task automatic test_heap_sizes();
        set_heap(32'hFFFF_FFF0, 25'h1FF_FFFF);
        send_item(ffha_pkg::CMD_ALLOC, 24'hFF_FFFF, '0);
        send_item(ffha_pkg::CMD_ALLOC, 24'hFF_FFF0, '0);
        free_random_live();
        set_heap(32'h0000_1000, 25'd8);
        send_item(ffha_pkg::CMD_ALLOC, 24'd1, '0);
        set_heap(32'hFFFF_FFFF, 25'd64);
        for (int i = 0; i < 5; i++)
            send_item(ffha_pkg::CMD_ALLOC, 24'($urandom_range(1, 24)), '0);
        for (int i = 0; i < 3; i++) free_random_live();
        send_item(ffha_pkg::CMD_ALLOC, 24'd52, '0);
    endtask

    // Fill the table with small blocks so no further split is possible.
    task automatic test_full_table();
        set_heap(ffha_pkg::HEAP_BASE_RST, ffha_pkg::HEAP_BYTES_RST);
        for (int i = 0; i < 70; i++)
            send_item(ffha_pkg::CMD_ALLOC, 24'($urandom_range(1, 16)), '0);
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 1) == 0) free_random_live();
            else send_item(ffha_pkg::CMD_ALLOC, 24'($urandom_range(1, 64)), '0);
        end
    endtask

    // Hold the output off for a long stretch while input keeps coming.
    task automatic test_backpressure();
        rx_hold = 400;
        for (int i = 0; i < 20; i++)
            send_item(ffha_pkg::CMD_ALLOC, 24'($urandom_range(1, 100)), '0);
        wait_drain();
    endtask

    // Mostly allocate and free of live blocks, with some noise.
    task automatic test_random(input int n_items);
        int pick;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if ($urandom_range(0, 15) == 0)
                    send_item(ffha_pkg::CMD_ALLOC, 24'($urandom), $urandom);
                else
                    send_item(ffha_pkg::CMD_ALLOC, 24'($urandom_range(0, 400)), $urandom);
            end else if (pick < 90) begin
                free_random_live();
            end else if (pick < 95) begin
                send_item(ffha_pkg::CMD_FREE, 24'($urandom), $urandom);
            end else if (pick < 98) begin
                send_item(2'd3, 24'($urandom), $urandom);
            end else begin
                send_item(ffha_pkg::CMD_REINIT, 24'($urandom), $urandom);
            end
        end
    endtask

    // Output ready, with random bursts of stall and an optional long hold.
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            m_axis_tready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rx_gap <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge i_clk) begin
        t_resp want;
        t_resp got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.status = m_axis_tdata[1:0];
            got.paddr = m_axis_tdata[33:2];
            got.total = m_axis_tdata[58:34];
            if (pending_resp.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %h", got);
            end else begin
                want = pending_resp.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: status %0d/%0d addr %h/%h total %0d/%0d",
                                 want.status, got.status, want.paddr, got.paddr,
                                 want.total, got.total);
                end
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = ffha_pkg::CFG_HEAP_BASE;
        i_cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = ffha_pkg::CMD_ALLOC;
        m_axis_tready = 1'b0;
        mismatches = 0;
        rx_hold = 0;
        rx_gap = 0;
        idle_on = 1'b1;
        reg_base = ffha_pkg::HEAP_BASE_RST;
        reg_bytes = ffha_pkg::HEAP_BYTES_RST;
        heap_rebuild();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_commands();
        test_heap_sizes();
        test_full_table();
        test_backpressure();
        set_heap(32'h8000_0000, 25'd2048);
        test_random(130);
        set_heap($urandom, 25'($urandom_range(64, 8192)));
        test_random(130);
        set_heap(32'h0000_0000, ffha_pkg::HEAP_LIMIT);
        test_random(100);
        idle_on = 1'b0;
        set_heap(ffha_pkg::HEAP_BASE_RST, 25'd4096);
        test_random(60);

        wait_drain();
        repeat (300) @(posedge i_clk);
        if (mismatches == 0 && pending_resp.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
sv/ffha_pkg.sv
sv/ffha_ctrl.sv
sv/ffha_dpath.sv
sv/first_fit_heap_allocator.sv
sim/tb.sv
